// ----- src/fxa_pkg.sv -----
// Shared types and constants for the Q16.16 fixed-point arithmetic unit.
// No dependencies; used by fxa_prep, fxa_cell, the top level and the testbench.
`default_nettype none

package fxa_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int XW            = WORD_W + FRACTION_BITS;
    localparam int NUM_CELLS     = XW;
    localparam int MUL_STEPS     = WORD_W;

    localparam int EXP_W         = 8;
    localparam int MANT_W        = 23;
    localparam int EXP_BIAS      = 127;
    localparam int CVT_SH_W      = 10;
    localparam int CVT_OFFSET    = EXP_BIAS + MANT_W - FRACTION_BITS;

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_DIV = 2'd1,
        CMD_CVT = 2'd2,
        CMD_ABS = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic                neg;
        logic                dbz;
        logic [XW-1:0]       x;
        logic [WORD_W:0]     acc;
        logic [WORD_W-1:0]   m;
    } t_cell;

endpackage

`default_nettype wire

// ----- src/fxa_if.sv -----
// Request and response channel interfaces of the fixed-point arithmetic unit.
// Depends on nothing; valid/ready handshake with payload.
`default_nettype none

interface fxa_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface fxa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               divide_by_zero;

    modport source (output valid, output result, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// ----- src/fxa_prep.sv -----
// Entry stage: operand magnitudes, sign, float-bits convert, cell seeding.
// Depends on fxa_pkg.
`default_nettype none

module fxa_prep (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  wire  [1:0]            i_cmd,
    input  wire  [31:0]           i_a,
    input  wire  [31:0]           i_b,
    output logic                  o_valid,
    output fxa_pkg::t_cell        o_data
);

    logic                                  r_valid;
    fxa_pkg::t_cell                        r_data;
    fxa_pkg::t_cell                        n_data;
    fxa_pkg::t_cmd                         cmd;
    logic [fxa_pkg::WORD_W-1:0]            mag_a;
    logic [fxa_pkg::WORD_W-1:0]            mag_b;
    logic [fxa_pkg::WORD_W-1:0]            mant32;
    logic signed [fxa_pkg::CVT_SH_W-1:0]   cvt_sh;
    logic signed [fxa_pkg::CVT_SH_W-1:0]   cvt_nsh;
    logic [fxa_pkg::WORD_W-1:0]            cvt_val;

    assign cmd    = fxa_pkg::t_cmd'(i_cmd);
    assign mag_a  = i_a[fxa_pkg::WORD_W-1] ? (~i_a + 32'd1) : i_a;
    assign mag_b  = i_b[fxa_pkg::WORD_W-1] ? (~i_b + 32'd1) : i_b;
    assign mant32 = {{(fxa_pkg::WORD_W - fxa_pkg::MANT_W - 1){1'b0}}, 1'b1,
                     i_a[fxa_pkg::MANT_W-1:0]};
    assign cvt_sh = $signed({2'b00, i_a[fxa_pkg::MANT_W +: fxa_pkg::EXP_W]})
                    - $signed(fxa_pkg::CVT_SH_W'(fxa_pkg::CVT_OFFSET));
    assign cvt_nsh = -cvt_sh;

    always_comb begin
        if (i_a == 32'd0) begin
            cvt_val = '0;
        end else if (cvt_sh >= 10'sd32 || cvt_sh <= -10'sd32) begin
            cvt_val = '0;
        end else if (!cvt_sh[fxa_pkg::CVT_SH_W-1]) begin
            cvt_val = mant32 << cvt_sh[4:0];
        end else begin
            cvt_val = mant32 >> cvt_nsh[4:0];
        end
    end

    always_comb begin
        n_data.cmd = cmd;
        n_data.neg = i_a[fxa_pkg::WORD_W-1] ^ i_b[fxa_pkg::WORD_W-1];
        n_data.dbz = 1'b0;
        n_data.acc = '0;
        n_data.m   = mag_b;
        n_data.x   = {{fxa_pkg::FRACTION_BITS{1'b0}}, mag_a};
        case (cmd)
            fxa_pkg::CMD_MUL: begin
                n_data.m = mag_a;
                n_data.x = {{fxa_pkg::FRACTION_BITS{1'b0}}, mag_b};
            end
            fxa_pkg::CMD_DIV: begin
                n_data.dbz = (i_b == 32'd0);
                n_data.x   = {mag_a, {fxa_pkg::FRACTION_BITS{1'b0}}};
            end
            fxa_pkg::CMD_CVT: begin
                n_data.neg = i_a[fxa_pkg::WORD_W-1];
                n_data.x   = {{fxa_pkg::FRACTION_BITS{1'b0}}, cvt_val};
            end
            default: begin
                n_data.neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/fxa_cell.sv -----
// One cell of the arithmetic chain: one shift-add multiply step (when enabled),
// one restoring divide step or a pass-through per item. Depends on fxa_pkg.
`default_nettype none

module fxa_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_mul_en,
    input  wire                   i_valid,
    input  fxa_pkg::t_cell        i_data,
    output logic                  o_valid,
    output fxa_pkg::t_cell        o_data
);

    logic                          r_valid;
    fxa_pkg::t_cell                r_data;
    fxa_pkg::t_cell                n_data;
    logic [fxa_pkg::WORD_W:0]      mul_sum;
    logic [fxa_pkg::WORD_W:0]      div_rem;
    logic [fxa_pkg::WORD_W+1:0]    div_diff;
    logic                          div_ge;

    assign mul_sum  = i_data.acc + (i_data.x[0] ? {1'b0, i_data.m} : '0);
    assign div_rem  = {i_data.acc[fxa_pkg::WORD_W-1:0], i_data.x[fxa_pkg::XW-1]};
    assign div_diff = {1'b0, div_rem} - {2'b00, i_data.m};
    assign div_ge   = ~div_diff[fxa_pkg::WORD_W+1];

    always_comb begin
        n_data = i_data;
        case (i_data.cmd)
            fxa_pkg::CMD_MUL: begin
                if (i_mul_en) begin
                    n_data.acc = {1'b0, mul_sum[fxa_pkg::WORD_W:1]};
                    n_data.x   = {i_data.x[fxa_pkg::XW-1:fxa_pkg::WORD_W], mul_sum[0],
                                  i_data.x[fxa_pkg::WORD_W-1:1]};
                end
            end
            fxa_pkg::CMD_DIV: begin
                n_data.acc = div_ge ? div_diff[fxa_pkg::WORD_W:0] : div_rem;
                n_data.x   = {i_data.x[fxa_pkg::XW-2:0], div_ge};
            end
            default: begin
                n_data = i_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/fixed_16_16_arith_unit.sv -----
// Top level of the Q16.16 arithmetic unit: entry stage, chain of cells,
// sign and select into the response register. Depends on fxa_pkg, fxa_if,
// fxa_prep, fxa_cell.
//
//   channel  direction  payload
//   i_req    in         command[1:0], operand_a[31:0], operand_b[31:0]
//   o_rsp    out        result[31:0], divide_by_zero
//
// The pipeline is one entry stage, one cell per quotient bit (32 + fraction
// bits) and one response register. One request is taken per cycle unless
// the chain holds; the whole chain advances together.
// The chain holds while a response waits and o_rsp.ready is low.
// Reset clears only the valid bits; the data registers are not reset.
`default_nettype none

module fixed_16_16_arith_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fxa_req_if.sink    i_req,
    fxa_rsp_if.source  o_rsp
);

    logic                    en;
    logic                    stage_valid [fxa_pkg::NUM_CELLS+1];
    fxa_pkg::t_cell          stage_data  [fxa_pkg::NUM_CELLS+1];
    fxa_pkg::t_cell          last;
    logic [2*fxa_pkg::WORD_W-1:0] prod;
    logic [fxa_pkg::WORD_W-1:0]   mag_v;
    logic [fxa_pkg::WORD_W-1:0]   n_result;

    logic                          r_rsp_valid;
    logic [fxa_pkg::WORD_W-1:0]    r_result;
    logic                          r_dbz;

    assign en          = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = en;

    fxa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_cmd   (i_req.command),
        .i_a     (i_req.operand_a),
        .i_b     (i_req.operand_b),
        .o_valid (stage_valid[0]),
        .o_data  (stage_data[0])
    );

    for (genvar k = 0; k < fxa_pkg::NUM_CELLS; k++) begin : g_cell
        fxa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_mul_en (k < fxa_pkg::MUL_STEPS),
            .i_valid  (stage_valid[k]),
            .i_data   (stage_data[k]),
            .o_valid  (stage_valid[k+1]),
            .o_data   (stage_data[k+1])
        );
    end

    assign last  = stage_data[fxa_pkg::NUM_CELLS];
    assign prod  = {last.acc[fxa_pkg::WORD_W-1:0], last.x[fxa_pkg::WORD_W-1:0]};
    assign mag_v = (last.cmd == fxa_pkg::CMD_MUL)
                   ? prod[fxa_pkg::FRACTION_BITS +: fxa_pkg::WORD_W]
                   : last.x[fxa_pkg::WORD_W-1:0];

    always_comb begin
        if (last.dbz) begin
            n_result = '0;
        end else if (last.neg) begin
            n_result = ~mag_v + 32'd1;
        end else begin
            n_result = mag_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (en) begin
            r_rsp_valid <= stage_valid[fxa_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_result <= n_result;
            r_dbz    <= last.dbz;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.result         = r_result;
    assign o_rsp.divide_by_zero = r_dbz;

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_by_zero |-> o_rsp.result == 32'd0)
        else $error("divide by zero response carries nonzero result");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request taken while response stalled");

    a_mul_hi_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_valid[fxa_pkg::NUM_CELLS] && last.cmd == fxa_pkg::CMD_MUL
        |-> !last.acc[fxa_pkg::WORD_W])
        else $error("multiply high word overflowed");

    a_div_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_valid[fxa_pkg::NUM_CELLS] && last.cmd == fxa_pkg::CMD_DIV && !last.dbz
        |-> last.acc < {1'b0, last.m})
        else $error("divide remainder not below divisor");

    a_entry_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> stage_valid[0])
        else $error("accepted request missing from entry stage");

endmodule

`default_nettype wire

// ----- verif/tb_fixed_16_16_arith_unit.sv -----
// Testbench for fixed_16_16_arith_unit: directed table then random requests, every
// response checked against table or Q16.16 predictor. Depends on fxa_pkg, fxa_if.
`timescale 1ns / 1ps

module tb_fixed_16_16_arith_unit;

    localparam int F_BIAS      = 127;
    localparam int F_MANT      = 23;
    localparam int RAND_ITEMS  = 1000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 60;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        logic [31:0] result;
        logic        dbz;
    } t_alu_out;

    typedef struct {
        fxa_pkg::t_cmd cmd;
        logic [31:0]   a;
        logic [31:0]   b;
        bit            typed;
        t_alu_out      out;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fxa_req_if req_if();
    fxa_rsp_if rsp_if();

    fixed_16_16_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    t_alu_out      q16_results_due[$];
    t_directed_row directed[$];
    int            send_idle;
    int            recv_idle;
    int            sent_count;
    int            hold_at;
    int            hold_left;
    bit            hold_done;
    int            errors;
    int            checked;
    int            dbz_seen;
    int            stall_cycles;
    int            cycle_count;
    int            cmd_count[4];
    t_alu_out      got;
    t_alu_out      want;

    function automatic t_alu_out q16_compute(fxa_pkg::t_cmd cmd, logic [31:0] a,
                                             logic [31:0] b);
        t_alu_out    r;
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mag;
        logic [31:0] mant;
        logic [63:0] prod;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        int          sh;
        r.dbz = 1'b0;
        mag   = '0;
        neg   = a[31] ^ b[31];
        ma    = a[31] ? (~a + 32'd1) : a;
        mb    = b[31] ? (~b + 32'd1) : b;
        case (cmd)
            fxa_pkg::CMD_MUL: begin
                prod = {32'b0, ma} * {32'b0, mb};
                mag  = prod[fxa_pkg::FRACTION_BITS +: 32];
            end
            fxa_pkg::CMD_DIV: begin
                if (b == 32'd0) begin
                    r.dbz = 1'b1;
                end else begin
                    quo  = {32'b0, ma} / {32'b0, mb};
                    rem  = {32'b0, ma} % {32'b0, mb};
                    frac = '0;
                    for (int i = 0; i < fxa_pkg::FRACTION_BITS; i++) begin
                        rem  = rem << 1;
                        frac = frac << 1;
                        if (rem >= {32'b0, mb}) begin
                            rem     = rem - {32'b0, mb};
                            frac[0] = 1'b1;
                        end
                    end
                    prod = (quo << fxa_pkg::FRACTION_BITS) | frac;
                    mag  = prod[31:0];
                end
            end
            fxa_pkg::CMD_CVT: begin
                neg = a[31];
                if (a != 32'd0) begin
                    mant = {8'b0, 1'b1, a[22:0]};
                    sh   = int'({24'b0, a[30:23]})
                           - (F_BIAS + F_MANT - fxa_pkg::FRACTION_BITS);
                    if (sh >= 32 || sh <= -32)
                        mag = '0;
                    else if (sh >= 0)
                        mag = mant << sh;
                    else
                        mag = mant >> (-sh);
                end
            end
            default: begin
                neg = 1'b0;
                mag = ma;
            end
        endcase
        r.result = neg ? (~mag + 32'd1) : mag;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0:       v = 32'h00000000;
                    1:       v = 32'h80000000;
                    2:       v = 32'h7FFFFFFF;
                    3:       v = 32'hFFFFFFFF;
                    default: v = 32'h00010000;
                endcase
            end
            1, 2: begin
                v = $urandom_range(32'h0003FFFF);
                if ($urandom_range(1) == 1)
                    v = ~v + 32'd1;
            end
            3: v = $urandom_range(255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_float();
        logic [31:0] m;
        logic [7:0]  e;
        m = $urandom;
        if ($urandom_range(9) == 0)
            e = 8'($urandom_range(255));
        else
            e = 8'($urandom_range(168, 100));
        return {m[31], e, m[22:0]};
    endfunction

    task automatic row(fxa_pkg::t_cmd cmd, logic [31:0] a, logic [31:0] b, bit typed,
                       logic [31:0] res, logic dbz);
        t_directed_row d;
        d.cmd        = cmd;
        d.a          = a;
        d.b          = b;
        d.typed      = typed;
        d.out.result = res;
        d.out.dbz    = dbz;
        directed.push_back(d);
    endtask

    task automatic send_request(fxa_pkg::t_cmd cmd, logic [31:0] a, logic [31:0] b,
                                t_alu_out exp);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.command   <= cmd;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        q16_results_due.push_back(exp);
        cmd_count[int'(cmd)]++;
        if (exp.dbz)
            dbz_seen++;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sent_count++;
    endtask

    // receiver: random stalls, plus one long hold-off once hold_at requests are in
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (!hold_done && sent_count >= hold_at) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (req_if.valid && !req_if.ready)
            stall_cycles++;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.result = rsp_if.result;
            got.dbz    = rsp_if.divide_by_zero;
            if (q16_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected response result=%h dbz=%b",
                         $time, got.result, got.dbz);
            end else begin
                want = q16_results_due.pop_front();
                checked++;
                if (got.result !== want.result) begin
                    errors++;
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want.result, got.result);
                end
                if (got.dbz !== want.dbz) begin
                    errors++;
                    $display("%0t: divide_by_zero mismatch expected %b actual %b",
                             $time, want.dbz, got.dbz);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding",
                     $time, q16_results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        fxa_pkg::t_cmd cmd;
        logic [31:0]   a;
        logic [31:0]   b;
        t_alu_out      exp;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.command   = fxa_pkg::CMD_MUL;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        hold_at          = 1 << 30;
        send_idle        = 17;
        recv_idle        = 76;

        row(fxa_pkg::CMD_MUL, 32'h00010000, 32'h00010000, 1, 32'h00010000, 1'b0);
        row(fxa_pkg::CMD_MUL, 32'hFFFF0000, 32'h00020000, 1, 32'hFFFE0000, 1'b0);
        row(fxa_pkg::CMD_MUL, 32'h80000000, 32'h80000000, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_MUL, 32'h00000000, 32'h80000000, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0, 1'b0);
        row(fxa_pkg::CMD_MUL, 32'h80000000, 32'h7FFFFFFF, 0, '0, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h12345678, 32'h00000000, 1, 32'h00000000, 1'b1);
        row(fxa_pkg::CMD_DIV, 32'h80000000, 32'h00000000, 1, 32'h00000000, 1'b1);
        row(fxa_pkg::CMD_DIV, 32'h00010000, 32'h00010000, 1, 32'h00010000, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h80000000, 32'h00000001, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h80000000, 32'h80000000, 1, 32'h00010000, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h00010000, 32'h00030000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, '0, 1'b0);
        row(fxa_pkg::CMD_DIV, 32'h00000001, 32'h80000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h00000000, 32'hFFFFFFFF, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h3F800000, 32'h00000000, 1, 32'h00010000, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'hBF800000, 32'h00000000, 1, 32'hFFFF0000, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h80000000, 32'h00000000, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h7F800000, 32'h00000000, 1, 32'h00000000, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h7FFFFFFF, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h52800001, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h53000000, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h33FFFFFF, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h337FFFFF, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_CVT, 32'h00000001, 32'h00000000, 0, '0, 1'b0);
        row(fxa_pkg::CMD_ABS, 32'h80000000, 32'h00000000, 1, 32'h80000000, 1'b0);
        row(fxa_pkg::CMD_ABS, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h00000001, 1'b0);
        row(fxa_pkg::CMD_ABS, 32'h7FFFFFFF, 32'h80000000, 1, 32'h7FFFFFFF, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            exp = directed[i].typed ? directed[i].out
                                    : q16_compute(directed[i].cmd, directed[i].a,
                                                  directed[i].b);
            send_request(directed[i].cmd, directed[i].a, directed[i].b, exp);
        end

        hold_at = directed.size() + 800;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                send_idle = 76;
                recv_idle = 17;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            cmd = fxa_pkg::t_cmd'($urandom_range(3));
            a   = (cmd == fxa_pkg::CMD_CVT) ? pick_float() : pick_operand();
            if (cmd == fxa_pkg::CMD_DIV && $urandom_range(24) == 0)
                b = 32'd0;
            else
                b = (cmd == fxa_pkg::CMD_MUL || cmd == fxa_pkg::CMD_DIV)
                    ? pick_operand() : 32'($urandom);
            send_request(cmd, a, b, q16_compute(cmd, a, b));
        end
        req_if.valid <= 1'b0;

        while (q16_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("%0d requests: mul %0d, div %0d (%0d by zero), cvt %0d, abs %0d",
                 sent_count, cmd_count[0], cmd_count[1], dbz_seen, cmd_count[2],
                 cmd_count[3]);
        $display("%0d responses checked, %0d cycles with the request side stalled",
                 checked, stall_cycles);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fxa_pkg.sv
src/fxa_if.sv
src/fxa_prep.sv
src/fxa_cell.sv
src/fixed_16_16_arith_unit.sv
verif/tb_fixed_16_16_arith_unit.sv
